// ===== rtl/core/mpmc_pkg.sv =====
// ---------------------------------------------------------------------------
// mpmc_pkg: shared types and constants of the multitrack PCM mix compressor
// Field widths, lane and merge structs, and the compressor segment tables.
// ---------------------------------------------------------------------------
package mpmc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_TRACKS  = 8;
  localparam int MASK_W      = 8;
  localparam int MASK_LSB    = MAX_TRACKS * SAMPLE_W;
  localparam int IN_TDATA_W  = MASK_LSB + MASK_W;
  localparam int OUT_TDATA_W = SAMPLE_W;
  // sum of up to eight 16-bit samples
  localparam int SUM_W       = 19;
  localparam int CNT_W       = 4;
  localparam int LOW_W       = 15;
  localparam int PROD_W      = LOW_W + 3;
  localparam int SEG_W       = 3;
  localparam int SHIFT_W     = 4;
  localparam int NUM_SEGS    = 5;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_MIX
  } mix_kind_e;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
  } lane_t;

  typedef struct packed {
    mix_kind_e                  kind;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] last;
    logic                       block_last;
  } mix_t;

  function automatic logic [SHIFT_W-1:0] seg_shift(input logic [SEG_W-1:0] seg);
    logic [SHIFT_W-1:0] sh;
    unique case (seg)
      3'd0:    sh = 4'd3;
      3'd1:    sh = 4'd6;
      3'd2:    sh = 4'd9;
      3'd3:    sh = 4'd12;
      default: sh = 4'd15;
    endcase
    return sh;
  endfunction

  function automatic logic [SAMPLE_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
    logic [SAMPLE_W-1:0] base;
    unique case (seg)
      3'd0:    base = 16'd0;
      3'd1:    base = 16'd28672;
      3'd2:    base = 16'd32256;
      3'd3:    base = 16'd32704;
      default: base = 16'd32760;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/core/mpmc_lane.sv =====
// ---------------------------------------------------------------------------
// mpmc_lane: one track lane
// Registers the track sample, forced to zero when its mask bit is clear.
// ---------------------------------------------------------------------------
module mpmc_lane
  import mpmc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output lane_t                      lane_o
);

  lane_t lane_d, lane_q;

  always_comb begin
    lane_d.valid  = valid_i;
    lane_d.sample = valid_i ? sample_i : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== rtl/core/mpmc_merge.sv =====
// ---------------------------------------------------------------------------
// mpmc_merge: lane merge stage
// Sums the lane samples, counts valid lanes and picks the highest valid one.
// ---------------------------------------------------------------------------
module mpmc_merge
  import mpmc_pkg::*;
#(
  parameter int TRACKS = 8
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  lane_t lanes_i [TRACKS],
  input  logic  block_last_i,
  output mix_t  mix_o
);

  mix_t             mix_d, mix_q;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    mix_d.sum  = '0;
    mix_d.last = '0;
    cnt        = '0;
    for (int i = 0; i < TRACKS; i++) begin
      mix_d.sum = mix_d.sum + SUM_W'(lanes_i[i].sample);
      cnt       = cnt + CNT_W'(lanes_i[i].valid);
      if (lanes_i[i].valid) begin
        mix_d.last = lanes_i[i].sample;
      end
    end
    priority if (cnt == '0) begin
      mix_d.kind = KIND_NONE;
    end else if (cnt == CNT_W'(1)) begin
      mix_d.kind = KIND_ONE;
    end else begin
      mix_d.kind = KIND_MIX;
    end
    mix_d.block_last = block_last_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

// ===== rtl/core/mpmc_curve.sv =====
// ---------------------------------------------------------------------------
// mpmc_curve: compressor curve and output register
// Maps the mix magnitude through the five-segment curve and restores sign.
// ---------------------------------------------------------------------------
module mpmc_curve
  import mpmc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       en_i,
  input  mix_t                       mix_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       last_o
);

  logic [SUM_W-1:0]          mag;
  logic [SUM_W-LOW_W-1:0]    hi;
  logic [SEG_W-1:0]          seg;
  logic [LOW_W-1:0]          low;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         shifted;
  logic [SAMPLE_W-1:0]       val;
  logic [SAMPLE_W-1:0]       sample_d, sample_q;
  logic                      last_q;

  always_comb begin
    mag = mix_i.sum[SUM_W-1] ? SUM_W'(-mix_i.sum) : SUM_W'(mix_i.sum);
    hi  = mag[SUM_W-1:LOW_W];
    seg = (hi > (SUM_W-LOW_W)'(NUM_SEGS - 1)) ? SEG_W'(NUM_SEGS - 1) : hi[SEG_W-1:0];
    low = mag[LOW_W-1:0];
    // times seven as times eight minus one
    prod    = {low, 3'b000} - {3'b000, low};
    shifted = prod >> seg_shift(seg);
    val     = shifted[SAMPLE_W-1:0] + seg_base(seg);
    unique case (mix_i.kind)
      KIND_NONE: sample_d = '0;
      KIND_ONE:  sample_d = mix_i.last;
      KIND_MIX:  sample_d = mix_i.sum[SUM_W-1] ? -val : val;
      default:   sample_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= sample_d;
      last_q   <= mix_i.block_last;
    end
  end

  assign sample_o = sample_q;
  assign last_o   = last_q;

endmodule

// ===== rtl/core/multitrack_pcm_mix_compressor.sv =====
// ---------------------------------------------------------------------------
// multitrack_pcm_mix_compressor: multitrack PCM mixer with curve compressor
// Mixes up to TRACKS masked 16-bit tracks into one 16-bit sample, curve-compressed when two or more mix.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                                  | tlast
//  s_axis   | in  | sample_0..7 [127:0], valid_mask [135:128] | end_of_block
//  m_axis   | out | mixed_sample [15:0]                    | block_last
//
//  Three register stages: track lanes, lane merge (adder chain), curve.
//  One transfer per cycle in and out while the output is not stalled.
//  A stalled output holds its result; the earlier stages keep filling
//  until the first occupied stage cannot advance.
//  Reset clears the stage valid flags only.
// ---------------------------------------------------------------------------
module multitrack_pcm_mix_compressor
  import mpmc_pkg::*;
#(
  parameter int TRACKS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // sample_0 .. sample_7 (16 bits each), valid_mask (8 bits)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // mixed_sample (16 bits)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  lane_t lanes [TRACKS];
  mix_t  mix;
  logic  lane_valid_q, mix_valid_q, out_valid_q;
  logic  lane_en, mix_en, out_en;
  logic  eob_q;
  logic signed [SAMPLE_W-1:0] mixed;

  // advance a stage when it is empty or the next one advances
  assign out_en  = !out_valid_q || m_axis_tready_i;
  assign mix_en  = !mix_valid_q || out_en;
  assign lane_en = !lane_valid_q || mix_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
      mix_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (lane_en) begin
        lane_valid_q <= s_axis_tvalid_i;
      end
      if (mix_en) begin
        mix_valid_q <= lane_valid_q;
      end
      if (out_en) begin
        out_valid_q <= mix_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_en) begin
      eob_q <= s_axis_tlast_i;
    end
  end

  for (genvar i = 0; i < TRACKS; i++) begin : g_lane
    mpmc_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_en),
      .valid_i  (s_axis_tdata_i[MASK_LSB + i]),
      .sample_i (s_axis_tdata_i[i*SAMPLE_W +: SAMPLE_W]),
      .lane_o   (lanes[i])
    );
  end

  mpmc_merge #(
    .TRACKS (TRACKS)
  ) u_merge (
    .clk_i        (clk_i),
    .en_i         (mix_en),
    .lanes_i      (lanes),
    .block_last_i (eob_q),
    .mix_o        (mix)
  );

  mpmc_curve u_curve (
    .clk_i    (clk_i),
    .en_i     (out_en),
    .mix_i    (mix),
    .sample_o (mixed),
    .last_o   (m_axis_tlast_o)
  );

  assign s_axis_tready_o = lane_en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mixed;

endmodule

// ===== rtl/core/mpmc_checker.sv =====
// ---------------------------------------------------------------------------
// mpmc_checker: port checks for the multitrack PCM mix compressor
// Watches reset, stall behavior and pipeline flow at the top-level ports.
// ---------------------------------------------------------------------------
module mpmc_checker
  import mpmc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tlast_o
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // reset clears the valid flags asynchronously; check at the edge after the one that samples reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer ##1 m_axis_tready_i ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("transfer did not reach output");

endmodule

bind multitrack_pcm_mix_compressor mpmc_checker u_mpmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for multitrack_pcm_mix_compressor
// Streams masked eight-track sample positions through the mixer and holds
// each output transfer against an in-bench model of the mix and the
// five-segment compression curve. Output order is checked, and so is the
// tlast copy. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module testbench;
  import mpmc_pkg::*;

  localparam int TRACKS_CFG   = 8;
  localparam int DIRECTED_N   = 22;
  localparam int RANDOM_N     = 1330;
  localparam int CALM_AFTER   = 1150;
  localparam int DRAIN_AT     = 640;
  localparam int SETTLE_CYC   = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CURVE_SEGS   = 5;
  localparam int LOW_MASK     = 'h7FFF;

  typedef enum int {
    AMP_FULL,
    AMP_QUIET,
    AMP_MID,
    AMP_LOUD
  } amp_class_e;

  // Expected outputs in issue order, plus the mix model that fills them.
  class mix_scoreboard;
    typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
    } mix_out_t;

    mix_out_t pending_mixes[$];
    int       errors;
    int       checked;
    int       zero_hits;
    int       single_hits;
    int       seg_hits[CURVE_SEGS];
    int       curve_shift[CURVE_SEGS] = '{3, 6, 9, 12, 15};
    int       curve_base[CURVE_SEGS]  = '{0, 28672, 32256, 32704, 32760};

    task report_mismatch(input string what);
      errors++;
      $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function logic [SAMPLE_W-1:0] compress_mix(input logic [IN_TDATA_W-1:0] d);
      logic signed [SAMPLE_W-1:0] smp;
      logic signed [SAMPLE_W-1:0] only;
      int sum;
      int cnt;
      int mag;
      int seg;
      int val;
      sum  = 0;
      cnt  = 0;
      only = '0;
      for (int i = 0; i < TRACKS_CFG; i++) begin
        if (d[MASK_LSB+i]) begin
          smp  = d[i*SAMPLE_W +: SAMPLE_W];
          sum += smp;
          cnt++;
          only = smp;
        end
      end
      if (cnt == 0) begin
        zero_hits++;
        return '0;
      end
      if (cnt == 1) begin
        single_hits++;
        return only;
      end
      mag = (sum < 0) ? -sum : sum;
      seg = mag >> 15;
      if (seg > CURVE_SEGS - 1) begin
        seg = CURVE_SEGS - 1;
      end
      seg_hits[seg]++;
      val = (((mag & LOW_MASK) * 7) >> curve_shift[seg]) + curve_base[seg];
      // zero sum counts as positive
      if (sum < 0) begin
        val = -val;
      end
      return val[SAMPLE_W-1:0];
    endfunction

    function void note_input(input logic [IN_TDATA_W-1:0] d, input logic last);
      mix_out_t m;
      m.sample = compress_mix(d);
      m.last   = last;
      pending_mixes.insert(pending_mixes.size(), m);
    endfunction

    task check_result(input logic [SAMPLE_W-1:0] sample, input logic last);
      mix_out_t m;
      if (pending_mixes.size() == 0) begin
        report_mismatch($sformatf("output transfer %h with nothing pending", sample));
      end else begin
        m = pending_mixes.pop_front();
        if (sample !== m.sample) begin
          report_mismatch($sformatf("result %0d mixed_sample got %h want %h",
                                    checked, sample, m.sample));
        end
        if (last !== m.last) begin
          report_mismatch($sformatf("result %0d block_last got %b want %b",
                                    checked, last, m.last));
        end
        checked++;
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic                   s_last = 1'b0;
  logic                   m_ready = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  bit            idle_on = 1'b1;
  int            cycle_count = 0;
  mix_scoreboard sb = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  multitrack_pcm_mix_compressor #(
    .TRACKS(TRACKS_CFG)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Note every accepted input, then check every accepted output.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (s_valid && s_axis_tready_o) begin
        sb.note_input(s_data, s_last);
      end
      if (m_axis_tvalid_o && m_ready) begin
        sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
      end
    end
  end

  // Output back-pressure: random stall bursts while idling is enabled.
  always begin
    @(posedge clk_i);
    if (rst_n && idle_on && $urandom_range(0, 7) == 0) begin
      m_ready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      m_ready <= 1'b1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_tracks(
    input logic signed [SAMPLE_W-1:0] trk[MAX_TRACKS],
    input logic [MASK_W-1:0]          mask
  );
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      d[i*SAMPLE_W +: SAMPLE_W] = trk[i];
    end
    d[MASK_LSB +: MASK_W] = mask;
    return d;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input amp_class_e amp, input bit neg);
    int v;
    case (amp)
      AMP_QUIET: v = $urandom_range(0, 4094) - 2047;
      AMP_MID:   v = $urandom_range(0, 32766) - 16383;
      AMP_LOUD: begin
        v = $urandom_range(16384, 32767);
        if (neg) begin
          v = -v - 1;
        end
      end
      default:   v = $urandom_range(0, 65535);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Present one sample position and hold it until the transfer completes.
  task automatic send_mix(input logic [IN_TDATA_W-1:0] data, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= data;
    s_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_uniform(input logic signed [SAMPLE_W-1:0] v, input int n,
                              input logic last);
    logic signed [SAMPLE_W-1:0] trk[MAX_TRACKS];
    for (int i = 0; i < MAX_TRACKS; i++) begin
      trk[i] = v;
    end
    send_mix(pack_tracks(trk, MASK_W'((1 << n) - 1)), last);
  endtask

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] a,
                           input logic signed [SAMPLE_W-1:0] b, input logic last);
    logic signed [SAMPLE_W-1:0] trk[MAX_TRACKS];
    for (int i = 0; i < MAX_TRACKS; i++) begin
      trk[i] = pick_sample(AMP_FULL, 1'b0);
    end
    trk[2] = a;
    trk[5] = b;
    send_mix(pack_tracks(trk, 8'b0010_0100), last);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] trk[MAX_TRACKS];
    logic [MASK_W-1:0]          mask;
    amp_class_e                 amp;
    bit                         neg;
    int                         mode;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: empty mask, single-track pass-through at the extremes,
    // segment boundaries, zero sum, and full-scale sums that clamp to the top segment.
    send_uniform(16'sh7FFF, 0, 1'b0);
    send_uniform(16'sh8000, 0, 1'b1);
    send_uniform(16'sh8000, 1, 1'b0);
    for (int i = 0; i < MAX_TRACKS; i++) begin
      trk[i] = 16'sh0000;
    end
    trk[7] = 16'sh7FFF;
    send_mix(pack_tracks(trk, 8'h80), 1'b1);
    trk[3] = 16'sh8000;
    send_mix(pack_tracks(trk, 8'h08), 1'b0);
    send_pair(16'sh7FFF, 16'sh0001, 1'b0);
    send_pair(16'sh3FFF, 16'sh4000, 1'b1);
    send_pair(16'sh8000, 16'shFFFF, 1'b0);
    send_pair(16'sh0064, 16'shFF9C, 1'b0);
    send_pair(16'shC000, 16'shC000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b0);
    send_pair(16'shFFFF, 16'sh0000, 1'b0);
    for (int n = 2; n <= MAX_TRACKS; n++) begin
      send_uniform(16'sh7FFF, n, n[0]);
    end
    send_uniform(16'sh8000, MAX_TRACKS, 1'b1);
    for (int i = 0; i < MAX_TRACKS; i++) begin
      trk[i] = i[0] ? 16'sh8000 : 16'sh7FFF;
    end
    send_mix(pack_tracks(trk, 8'hFF), 1'b0);
    send_pair(16'sh5555, 16'shAAAA, 1'b1);

    // Random: mostly multi-track mixes at varied loudness, plus
    // single-track, silent and all-track positions.
    for (int k = 0; k < RANDOM_N; k++) begin
      if (k == DRAIN_AT) begin
        s_valid <= 1'b0;
        while (sb.pending_mixes.size() != 0) @(posedge clk_i);
      end
      if (k == CALM_AFTER) begin
        idle_on = 1'b0;
      end
      mode = $urandom_range(0, 9);
      amp  = amp_class_e'($urandom_range(0, 3));
      neg  = 1'($urandom_range(0, 1));
      case (mode)
        0:       mask = MASK_W'(1 << $urandom_range(0, MAX_TRACKS - 1));
        1:       mask = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: mask = MASK_W'($urandom_range(0, 255));
      endcase
      for (int i = 0; i < MAX_TRACKS; i++) begin
        trk[i] = pick_sample(amp, neg);
      end
      send_mix(pack_tracks(trk, mask), 1'($urandom_range(0, 1)));
    end
    s_valid <= 1'b0;

    while (sb.pending_mixes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.pending_mixes.size() != 0) begin
      sb.report_mismatch("expected results left over");
    end

    $display("Mixed %0d positions (%0d directed, %0d random): %0d silent, %0d single-track",
             sb.checked, DIRECTED_N, RANDOM_N, sb.zero_hits, sb.single_hits);
    $display("Curve segment hits 0..4: %0d %0d %0d %0d %0d; errors %0d", sb.seg_hits[0],
             sb.seg_hits[1], sb.seg_hits[2], sb.seg_hits[3], sb.seg_hits[4], sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
